@@ hdl/wrtl_pkg.sv @@
// Package for the wildcard rule table: channel word types, rule entry layout,
// status and opcode codes, and the controller states. No dependencies.
`default_nettype none

package wrtl_pkg;

  // Default number of rule slots in the table.
  localparam int RULE_SLOTS_DEF = 32;

  // Opcodes of an input word.
  localparam logic OP_MERGE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Part code that matches any part.
  localparam logic [2:0] PART_ANY = 3'd0;

  // Status codes of a result word.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NOMATCH = 2'd2;

  // Input word.
  typedef struct packed {
    logic        opcode;
    logic        net_wild;
    logic [15:0] net_number;
    logic [2:0]  from_part;
    logic [2:0]  to_part;
    logic        delete_rule;
    logic [31:0] flavor_rpc;
    logic [3:0]  bulk_hash;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [31:0] flavor_out;
    logic [3:0]  bulk_hash_out;
    logic [5:0]  rules_held;
  } out_word_t;

  // One stored rule; the network number is zero when the network is wild.
  typedef struct packed {
    logic        wild;
    logic [15:0] net;
    logic [2:0]  from_part;
    logic [2:0]  to_part;
    logic [31:0] flavor;
    logic [3:0]  hash;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHDN,
    S_SHUP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ hdl/wildcard_rule_table_merge_lookup.sv @@
// Top level of the ordered wildcard rule table with merge and lookup.
// Depends on wrtl_pkg and wrtl_ram.
//
// Usage:
//   The in_ channel carries one word per operation: a merge (overwrite,
//   insert or delete of a rule) or a lookup. Each word gives exactly one
//   result word on the out_ channel. The cfg_ channel writes the default
//   flavor returned by a lookup miss; it is always ready, and the user must
//   write it only while the block is idle; the block does not enforce this.
//   Words are handled one at a time. The rule table lives in one RAM with a
//   registered read, and the scan reads one entry per cycle until it stops
//   at a match or at the insert point, or runs through all the rules held.
//   An insert or delete then moves every later entry, one per cycle through
//   the same RAM port. The scan and the move together pass each entry about
//   once.
//   The result sits in an output register, so in_ready returns as soon as
//   the result is loaded even if the receiver stalls; a stalled result
//   holds until taken, and the next result waits behind it.
//   Reset empties the table (the rule count goes to zero; the RAM is not
//   cleared) and sets the default flavor to zero. No clearing pass is run.
`default_nettype none

module wildcard_rule_table_merge_lookup #(
  parameter int RULE_SLOTS = wrtl_pkg::RULE_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire wrtl_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wrtl_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [31:0]         cfg_data
);

  import wrtl_pkg::*;

  localparam int CW = $clog2(RULE_SLOTS + 1);
  localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  // Convert an input word into a stored rule.
  function automatic rule_t to_rule(input in_word_t w);
    rule_t r;
    r.wild      = w.net_wild;
    r.net       = w.net_wild ? 16'd0 : w.net_number;
    r.from_part = w.from_part;
    r.to_part   = w.to_part;
    r.flavor    = w.flavor_rpc;
    r.hash      = w.bulk_hash;
    return r;
  endfunction

  function automatic logic net_equal(input rule_t a, input rule_t b);
    return (a.wild || b.wild) ? (a.wild && b.wild) : (a.net == b.net);
  endfunction

  function automatic logic dir_specific(input rule_t r);
    return (r.from_part != PART_ANY) || (r.to_part != PART_ANY);
  endfunction

  // Registers.
  state_t          state_r, state_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   ck_r, ck_nxt;
  logic            vld_r, vld_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  in_word_t        item_r, item_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            hit_r, hit_nxt;
  logic [31:0]     flv_r, flv_nxt;
  logic [3:0]      hash_r, hash_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_data_r, out_data_nxt;
  logic [31:0]     dflt_r;

  // RAM ports.
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [RULE_W-1:0] wr_data, rd_data;

  // Scan decode.
  rule_t          ent, nr;
  logic           scan_hit, scan_brk, scan_done, scan_match;
  logic [CW-1:0]  scan_pos, idx_inc, idx_dec, pos_inc;

  assign ent     = rule_t'(rd_data);
  assign nr      = to_rule(item_r);
  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);

  wrtl_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Compare the entry just read against the held word.
  always_comb begin
    scan_hit = 1'b0;
    scan_brk = 1'b0;
    if (item_r.opcode == OP_LOOKUP) begin
      scan_hit = (nr.wild || ent.wild || (nr.net == ent.net)) &&
                 (nr.from_part == PART_ANY || ent.from_part == PART_ANY ||
                  nr.from_part == ent.from_part) &&
                 (nr.to_part == PART_ANY || ent.to_part == PART_ANY ||
                  nr.to_part == ent.to_part);
    end else if (!net_equal(ent, nr)) begin
      // Specific networks stay ahead of wildcard ones.
      scan_brk = !nr.wild && ent.wild;
    end else if ((ent.from_part != nr.from_part) || (ent.to_part != nr.to_part)) begin
      // Specific directions stay ahead of wildcard ones.
      scan_brk = dir_specific(nr) && !dir_specific(ent);
    end else begin
      scan_hit = 1'b1;
    end
    scan_done  = (vld_r && (scan_hit || scan_brk)) || (!vld_r && (idx_r >= cnt_r));
    scan_match = vld_r && scan_hit;
    scan_pos   = vld_r ? ck_r : cnt_r;
  end

  assign pos_inc = scan_pos + CW'(1);

  // Next state, RAM control and result formation.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ck_nxt        = ck_r;
    vld_nxt       = 1'b0;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    status_nxt    = status_r;
    hit_nxt       = hit_r;
    flv_nxt       = flv_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = ck_r[AW-1:0];
    wr_data       = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          idx_nxt    = '0;
          status_nxt = STATUS_OK;
          hit_nxt    = 1'b0;
          flv_nxt    = '0;
          hash_nxt   = '0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (scan_done) begin
          if (item_r.opcode == OP_LOOKUP) begin
            if (scan_match) begin
              hit_nxt  = 1'b1;
              flv_nxt  = ent.flavor;
              hash_nxt = ent.hash;
            end else begin
              flv_nxt  = dflt_r;
            end
            state_nxt = S_DONE;
          end else if (scan_match && !item_r.delete_rule) begin
            // Overwrite the exact match in place.
            wr_en     = 1'b1;
            wr_addr   = scan_pos[AW-1:0];
            wr_data   = nr;
            state_nxt = S_DONE;
          end else if (scan_match) begin
            // Delete: pull later entries down over the match.
            idx_nxt   = pos_inc;
            state_nxt = S_SHDN;
          end else if (item_r.delete_rule) begin
            status_nxt = STATUS_NOMATCH;
            state_nxt  = S_DONE;
          end else if (cnt_r >= CW'(RULE_SLOTS)) begin
            status_nxt = STATUS_FULL;
            state_nxt  = S_DONE;
          end else begin
            // Insert: push entries from the scan stop point up by one.
            pos_nxt   = scan_pos;
            idx_nxt   = cnt_r;
            state_nxt = S_SHUP;
          end
        end else if (idx_r < cnt_r) begin
          rd_en   = 1'b1;
          vld_nxt = 1'b1;
          ck_nxt  = idx_r;
          idx_nxt = idx_inc;
        end
      end

      S_SHDN: begin
        if (vld_r) begin
          wr_en = 1'b1;
        end
        if (!vld_r && (idx_r >= cnt_r)) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end else if (idx_r < cnt_r) begin
          rd_en   = 1'b1;
          vld_nxt = 1'b1;
          ck_nxt  = idx_dec;
          idx_nxt = idx_inc;
        end
      end

      S_SHUP: begin
        if (vld_r) begin
          wr_en = 1'b1;
        end
        if (!vld_r && (idx_r <= pos_r)) begin
          // The slot at the stop point is free now; place the new rule.
          wr_en     = 1'b1;
          wr_addr   = pos_r[AW-1:0];
          wr_data   = nr;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end else if (idx_r > pos_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_dec[AW-1:0];
          vld_nxt = 1'b1;
          ck_nxt  = idx_r;
          idx_nxt = idx_dec;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.hit           = hit_r;
          out_data_nxt.flavor_out    = flv_r;
          out_data_nxt.bulk_hash_out = hash_r;
          out_data_nxt.rules_held    = 6'(cnt_r);
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      dflt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        dflt_r <= cfg_data;
      end
    end
  end

  // Payload and index registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    ck_r       <= ck_nxt;
    pos_r      <= pos_nxt;
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    hit_r      <= hit_nxt;
    flv_r      <= flv_nxt;
    hash_r     <= hash_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ hdl/wrtl_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; width and depth come from parameters.
`default_nettype none

module wrtl_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/wrtl_checker.sv @@
// Port-level checker for the wildcard rule table, bound to the top level.
// Depends on wrtl_pkg and on the port list of wildcard_rule_table_merge_lookup.
`default_nettype none

module wrtl_checker #(
  parameter int RULE_SLOTS = wrtl_pkg::RULE_SLOTS_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire wrtl_pkg::out_word_t out_data
);

  import wrtl_pkg::*;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // One word at a time: the block is busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after an accept");

  // A refused insert is only reported on a full table.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_FULL) |->
      (out_data.rules_held == 6'(RULE_SLOTS)))
    else $error("table full reported with free slots");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wildcard_rule_table_merge_lookup wrtl_checker #(
  .RULE_SLOTS (RULE_SLOTS)
) u_wrtl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/sv/tb_wildcard_rule_table_merge_lookup.sv @@
// Self-checking testbench for wildcard_rule_table_merge_lookup: a directed table of
// words, then phases of random merges and lookups, each checked against a predictor or typed result.
// Depends on wrtl_pkg and the rule table RTL.
module tb_wildcard_rule_table_merge_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import wrtl_pkg::*;

  localparam int SLOTS      = 32;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_LEN  = 125;

  typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} traffic_t;

  // One directed step: the word, and the result where it is typed in.
  typedef struct {
    in_word_t  word;
    bit        fixed;
    out_word_t want;
  } step_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [31:0] cfg_data;

  // Sideband that travels with in_data: use the typed result instead of the predictor.
  bit        fixed_q;
  out_word_t fixed_want;

  // Predicted table contents and register.
  rule_t       rule_tab [SLOTS];
  int          rule_cnt;
  logic [31:0] dflt_flavor;

  out_word_t result_q [$];
  step_row_t rows [$];

  int  words_sent;
  int  results_seen;
  int  bad_cnt;
  int  idle_run;
  int  hold_off;
  bit  calm;
  int  n_lookup;
  int  n_hit;
  int  n_full;
  int  n_nomatch;
  int  n_cfg;

  wildcard_rule_table_merge_lookup #(
    .RULE_SLOTS(SLOTS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Two networks agree when both are wild or both carry the same number.
  function automatic bit same_net(rule_t a, rule_t b);
    if (a.wild || b.wild) return a.wild && b.wild;
    return a.net == b.net;
  endfunction

  function automatic bit has_dir(rule_t r);
    return r.from_part != PART_ANY || r.to_part != PART_ANY;
  endfunction

  // Applies one word to the predicted table and returns the result it should give.
  function automatic out_word_t apply_to_table(in_word_t w);
    out_word_t res;
    rule_t     nr;
    rule_t     p;
    int        pos;
    int        i;
    bit        stop;
    bit        found;
    res = '0;
    pos = 0;
    stop = 1'b0;
    found = 1'b0;
    if (w.opcode == OP_LOOKUP) begin
      res.status = STATUS_OK;
      res.flavor_out = dflt_flavor;
      while (!found && pos < rule_cnt) begin
        p = rule_tab[pos];
        if ((w.net_wild || p.wild || w.net_number == p.net) &&
            (w.from_part == PART_ANY || p.from_part == PART_ANY ||
             w.from_part == p.from_part) &&
            (w.to_part == PART_ANY || p.to_part == PART_ANY || w.to_part == p.to_part)) begin
          found = 1'b1;
          res.hit = 1'b1;
          res.flavor_out = p.flavor;
          res.bulk_hash_out = p.hash;
        end else begin
          pos++;
        end
      end
    end else begin
      nr.wild = w.net_wild;
      nr.net = w.net_wild ? 16'h0000 : w.net_number;
      nr.from_part = w.from_part;
      nr.to_part = w.to_part;
      nr.flavor = w.flavor_rpc;
      nr.hash = w.bulk_hash;
      // Specific rules sit ahead of wild ones, so the scan may stop early.
      while (!stop && pos < rule_cnt) begin
        p = rule_tab[pos];
        if (!same_net(p, nr)) begin
          if (!nr.wild && p.wild) stop = 1'b1;
          else pos++;
        end else if (p.from_part != nr.from_part || p.to_part != nr.to_part) begin
          if (has_dir(nr) && !has_dir(p)) stop = 1'b1;
          else pos++;
        end else begin
          found = 1'b1;
          stop = 1'b1;
        end
      end
      res.status = STATUS_OK;
      if (found) begin
        if (w.delete_rule) begin
          for (i = pos; i < rule_cnt - 1; i++) rule_tab[i] = rule_tab[i + 1];
          rule_cnt--;
        end else begin
          rule_tab[pos] = nr;
        end
      end else if (w.delete_rule) begin
        res.status = STATUS_NOMATCH;
      end else if (rule_cnt >= SLOTS) begin
        res.status = STATUS_FULL;
      end else begin
        for (i = rule_cnt; i > pos; i--) rule_tab[i] = rule_tab[i - 1];
        rule_tab[pos] = nr;
        rule_cnt++;
      end
    end
    res.rules_held = rule_cnt[5:0];
    return res;
  endfunction

  function automatic in_word_t mk_word(logic op, logic wild, logic [15:0] net,
                                       logic [2:0] fp, logic [2:0] tp, logic del,
                                       logic [31:0] flv, logic [3:0] hs);
    in_word_t w;
    w.opcode = op;
    w.net_wild = wild;
    w.net_number = net;
    w.from_part = fp;
    w.to_part = tp;
    w.delete_rule = del;
    w.flavor_rpc = flv;
    w.bulk_hash = hs;
    return w;
  endfunction

  function automatic out_word_t mk_out(logic [1:0] st, logic [5:0] held);
    out_word_t o;
    o = '0;
    o.status = st;
    o.rules_held = held;
    return o;
  endfunction

  function automatic void add_row(in_word_t w, bit fixed, out_word_t want);
    step_row_t r;
    r.word = w;
    r.fixed = fixed;
    r.want = want;
    rows.push_back(r);
  endfunction

  // Part codes lean toward the wildcard so that wild and specific rules mix.
  function automatic logic [2:0] pick_part();
    if ($urandom_range(0, 2) == 0) return PART_ANY;
    return 3'($urandom_range(1, 7));
  endfunction

  // Random word; many reuse a key already in the table so that they match.
  function automatic in_word_t pick_word(traffic_t mode);
    in_word_t w;
    rule_t    r;
    int       roll;
    bit       use_tab;
    logic     op;
    logic     del;
    w.flavor_rpc = $urandom;
    w.bulk_hash = 4'($urandom);
    w.net_wild = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 5))
      0: w.net_number = 16'h0000;
      1: w.net_number = 16'hFFFF;
      2, 3: w.net_number = 16'($urandom_range(1, 3));
      default: w.net_number = 16'($urandom);
    endcase
    w.from_part = pick_part();
    w.to_part = pick_part();
    roll = $urandom_range(0, 99);
    use_tab = 1'b0;
    op = OP_MERGE;
    del = 1'b0;
    case (mode)
      MODE_FILL: begin
        if (roll < 70) begin
          w.net_wild = 1'b0;
          w.net_number = 16'($urandom);
        end else if (roll < 85) begin
          op = OP_LOOKUP;
        end else begin
          use_tab = 1'b1;
        end
      end
      MODE_DRAIN: begin
        if (roll < 55) begin
          del = 1'b1;
          use_tab = 1'b1;
        end else if (roll < 80) begin
          op = OP_LOOKUP;
          use_tab = (roll < 70);
        end else begin
          del = (roll < 90);
        end
      end
      default: begin
        if (roll < 45) begin
          op = OP_LOOKUP;
          use_tab = (roll < 20);
        end else if (roll < 85) begin
          use_tab = (roll < 60);
        end else begin
          del = 1'b1;
          use_tab = (roll < 95);
        end
      end
    endcase
    if (use_tab && rule_cnt > 0) begin
      r = rule_tab[$urandom_range(0, rule_cnt - 1)];
      w.net_wild = r.wild;
      // A wild key may carry any number; it still names the same rule.
      w.net_number = r.wild ? 16'($urandom) : r.net;
      w.from_part = r.from_part;
      w.to_part = r.to_part;
    end
    w.opcode = op;
    // A lookup ignores the delete bit, so it gets a random one.
    w.delete_rule = (op == OP_LOOKUP) ? logic'($urandom_range(0, 1)) : del;
    return w;
  endfunction

  // Offers one input word, after an optional gap, and returns at its acceptance edge.
  task automatic send_word(in_word_t w, bit fixed, out_word_t want, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    fixed_q <= fixed;
    fixed_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Stops offering words and waits until every pending result has come back.
  task automatic settle_idle(int tail);
    in_valid <= 1'b0;
    while (results_seen != words_sent) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_default(logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stalls in short random bursts, none during reset or the calm tail.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ready <= 1'b1;
      hold_off = 0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      hold_off = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watches all three channels: predicts on each accepted input word and checks
  // each accepted result word against the oldest prediction.
  always @(posedge clk) begin : channel_watch
    out_word_t got;
    out_word_t due;
    out_word_t pred;
    bit        act;
    if (rst_n) begin
      act = 1'b0;
      if (cfg_valid && cfg_ready) begin
        dflt_flavor = cfg_data;
        n_cfg++;
        act = 1'b1;
      end
      if (out_valid && out_ready) begin
        act = 1'b1;
        got = out_data;
        results_seen++;
        if (result_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("unexpected result word: status %0d hit %0d flavor %h hash %0d held %0d",
                     got.status, got.hit, got.flavor_out, got.bulk_hash_out, got.rules_held);
        end else begin
          due = result_q.pop_front();
          if (got.status !== due.status || got.hit !== due.hit ||
              got.flavor_out !== due.flavor_out || got.bulk_hash_out !== due.bulk_hash_out ||
              got.rules_held !== due.rules_held) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display({"mismatch on result %0d (expected/actual): status %0d/%0d ",
                        "hit %0d/%0d flavor %h/%h hash %0d/%0d held %0d/%0d"},
                       results_seen, due.status, got.status, due.hit, got.hit,
                       due.flavor_out, got.flavor_out, due.bulk_hash_out, got.bulk_hash_out,
                       due.rules_held, got.rules_held);
          end
        end
      end
      if (in_valid && in_ready) begin
        act = 1'b1;
        pred = apply_to_table(in_data);
        if (in_data.opcode == OP_LOOKUP) n_lookup++;
        if (pred.hit) n_hit++;
        if (pred.status == STATUS_FULL) n_full++;
        if (pred.status == STATUS_NOMATCH) n_nomatch++;
        result_q.push_back(fixed_q ? fixed_want : pred);
      end
      idle_run = act ? 0 : idle_run + 1;
    end
  end

  // Ends a run in which no channel has moved a word for too long.
  initial begin : watchdog
    while (idle_run < IDLE_LIMIT) @(posedge clk);
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("[wildcard_rule_table_merge_lookup] ERROR");
    $finish;
  end

  initial begin : stimulus
    traffic_t    mode;
    logic [31:0] setting;
    int          ph;
    int          k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    fixed_q = 1'b0;
    fixed_want = '0;
    calm = 1'b0;
    rule_cnt = 0;
    dflt_flavor = '0;
    words_sent = 0;
    results_seen = 0;
    bad_cnt = 0;
    idle_run = 0;
    hold_off = 0;
    n_lookup = 0;
    n_hit = 0;
    n_full = 0;
    n_nomatch = 0;
    n_cfg = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words; the first ones start from an empty table and a zero default.
    add_row(mk_word(OP_LOOKUP, 1, 16'h0000, 0, 0, 0, 32'h0, 4'h0), 1,
            mk_out(STATUS_OK, 6'd0));
    add_row(mk_word(OP_MERGE, 0, 16'h0007, 1, 1, 1, 32'h0, 4'h0), 1,
            mk_out(STATUS_NOMATCH, 6'd0));
    add_row(mk_word(OP_MERGE, 1, 16'h0000, 0, 0, 0, 32'hFFFF_FFFF, 4'hF), 1,
            mk_out(STATUS_OK, 6'd1));
    add_row(mk_word(OP_MERGE, 0, 16'hFFFF, 7, 7, 0, 32'h0000_0000, 4'h0), 1,
            mk_out(STATUS_OK, 6'd2));
    add_row(mk_word(OP_MERGE, 0, 16'h0000, 1, 2, 0, 32'h0000_0001, 4'h1), 1,
            mk_out(STATUS_OK, 6'd3));
    add_row(mk_word(OP_LOOKUP, 0, 16'hFFFF, 7, 7, 0, 32'h0, 4'h0), 0, '0);
    // A lookup ignores the delete bit, the flavor and the hash it carries.
    add_row(mk_word(OP_LOOKUP, 1, 16'hABCD, 0, 0, 1, 32'hFFFF_FFFF, 4'hF), 0, '0);
    // A wild network with a nonzero number still names the stored wild rule.
    add_row(mk_word(OP_MERGE, 1, 16'hFFFF, 0, 0, 0, 32'h1234_5678, 4'h3), 0, '0);
    add_row(mk_word(OP_LOOKUP, 0, 16'h1111, 5, 6, 0, 32'h0, 4'h0), 0, '0);
    add_row(mk_word(OP_MERGE, 0, 16'h1111, 5, 6, 0, 32'hA5A5_A5A5, 4'hA), 0, '0);
    add_row(mk_word(OP_MERGE, 0, 16'h0000, 7, 0, 0, 32'h0F0F_0F0F, 4'h7), 0, '0);
    add_row(mk_word(OP_MERGE, 0, 16'h0000, 0, 7, 0, 32'hF0F0_F0F0, 4'h8), 0, '0);
    add_row(mk_word(OP_LOOKUP, 0, 16'h0000, 1, 0, 0, 32'h0, 4'h0), 0, '0);
    add_row(mk_word(OP_LOOKUP, 0, 16'h1111, 0, 6, 0, 32'h0, 4'h0), 0, '0);
    add_row(mk_word(OP_MERGE, 0, 16'hFFFF, 7, 7, 0, 32'h5555_AAAA, 4'h5), 0, '0);
    add_row(mk_word(OP_MERGE, 0, 16'hFFFF, 7, 7, 1, 32'h0, 4'h0), 0, '0);
    add_row(mk_word(OP_MERGE, 0, 16'hFFFF, 7, 7, 1, 32'h0, 4'h0), 0, '0);
    add_row(mk_word(OP_MERGE, 1, 16'h0000, 0, 0, 1, 32'h0, 4'h0), 0, '0);
    add_row(mk_word(OP_LOOKUP, 0, 16'h2222, 3, 3, 0, 32'h0, 4'h0), 0, '0);
    add_row(mk_word(OP_MERGE, 0, 16'h8000, 0, 0, 0, 32'h8000_0000, 4'h2), 0, '0);
    add_row(mk_word(OP_LOOKUP, 1, 16'h0000, 0, 0, 0, 32'h0, 4'h0), 0, '0);
    add_row(mk_word(OP_MERGE, 1, 16'h0000, 4, 4, 1, 32'h0, 4'h0), 0, '0);
    add_row(mk_word(OP_LOOKUP, 0, 16'h8000, 4, 4, 0, 32'h0, 4'h0), 0, '0);
    foreach (rows[i]) send_word(rows[i].word, rows[i].fixed, rows[i].want, 1'b1);

    // Random phases, each under its own default flavor; the last one runs calm.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin setting = 32'hFFFF_FFFF; mode = MODE_MIX;   end
        1: begin setting = $urandom;      mode = MODE_FILL;  end
        2: begin setting = 32'h0000_0000; mode = MODE_DRAIN; end
        3: begin setting = 32'h8000_0000; mode = MODE_MIX;   end
        4: begin setting = $urandom;      mode = MODE_FILL;  end
        default: begin setting = $urandom; mode = MODE_DRAIN; end
      endcase
      settle_idle(4);
      write_default(setting);
      if (ph == 5) calm = 1'b1;
      for (k = 0; k < PHASE_LEN; k++) send_word(pick_word(mode), 1'b0, '0, !calm);
    end

    settle_idle(80);
    if (result_q.size() != 0) begin
      $display("%0d expected result words never arrived", result_q.size());
      bad_cnt += result_q.size();
    end
    $display("Covered %0d words: %0d lookups with %0d hits, %0d refused inserts on a full table,",
             words_sent, n_lookup, n_hit, n_full);
    $display("%0d deletes with no matching rule, %0d default flavor writes, %0d failures.",
             n_nomatch, n_cfg, bad_cnt);
    if (bad_cnt == 0) begin
      $display("[wildcard_rule_table_merge_lookup] OK");
    end else begin
      $display("[wildcard_rule_table_merge_lookup] ERROR");
    end
    $finish;
  end

endmodule
